// File: hdl/whp_pkg.sv
// Shared constants, codes and types of the WAV header parser.
`default_nettype none
package whp_pkg;

    // Width of the byte counter and of the stored tag positions.
    localparam int COUNT_BITS = 32;
    // Width that holds a position plus eight plus a 32-bit chunk size without wrap.
    localparam int SUM_W = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 2;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam int MIN_FILE_LEN  = 44;
    localparam int RIFF_END      = 3;
    localparam int WAVE_END      = 11;
    localparam int TAG_SCAN_END  = 15;
    localparam int FMT_TAIL      = 24;
    localparam int DATA_HDR_LEN  = 8;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_NO_RIFF = 3'd2,
        ST_NO_WAVE = 3'd3,
        ST_NO_FMT  = 3'd4,
        ST_NO_DATA = 3'd5,
        ST_OVERRUN = 3'd6
    } t_status;

    // Header state gathered while the file streams through.
    typedef struct packed {
        logic [COUNT_BITS-1:0] byte_count;
        logic                  riff_seen;
        logic                  wave_seen;
        logic                  fmt_found;
        logic [COUNT_BITS-1:0] fmt_position;
        logic                  data_found;
        logic [COUNT_BITS-1:0] data_position;
        logic [31:0]           rate;
        logic [15:0]           channels;
        logic [31:0]           size;
    } t_track;

endpackage
`default_nettype wire

// File: hdl/whp_if.sv
// Valid/ready stream interfaces for the byte input and the header result.
`default_nettype none
interface whp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       is_last;

    modport source (output valid, output file_byte, output is_last, input ready);
    modport sink   (input valid, input file_byte, input is_last, output ready);
endinterface

interface whp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;

    modport source (output valid, output status, output sample_rate,
                    output channel_count, output payload_offset,
                    output payload_size, input ready);
    modport sink   (input valid, input status, input sample_rate,
                    input channel_count, input payload_offset,
                    input payload_size, output ready);
endinterface
`default_nettype wire

// File: hdl/whp_tracker.sv
// Tag window, byte counter, tag search and little-endian field capture.
`default_nettype none
module whp_tracker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_file_byte,
    input  wire logic            i_is_last,
    output whp_pkg::t_track      o_track
);

    localparam int CB = whp_pkg::COUNT_BITS;

    logic [31:0]      r_window;
    logic [31:0]      n_window;
    whp_pkg::t_track  r_track;
    whp_pkg::t_track  n_track;
    logic [CB-1:0]    w_fmt_dist;
    logic [CB-1:0]    w_data_dist;
    logic             w_scan;

    assign n_window    = {r_window[23:0], i_file_byte};
    assign w_fmt_dist  = r_track.byte_count - r_track.fmt_position;
    assign w_data_dist = r_track.byte_count - r_track.data_position;
    assign w_scan      = (r_track.byte_count >= CB'(whp_pkg::TAG_SCAN_END));

    always_comb begin
        n_track = r_track;

        if (r_track.byte_count == CB'(whp_pkg::RIFF_END) && n_window == whp_pkg::TAG_RIFF) begin
            n_track.riff_seen = 1'b1;
        end
        if (r_track.byte_count == CB'(whp_pkg::WAVE_END) && n_window == whp_pkg::TAG_WAVE) begin
            n_track.wave_seen = 1'b1;
        end
        // Positions refer to the first byte of the tag, three bytes back.
        if (w_scan && !r_track.fmt_found && n_window == whp_pkg::TAG_FMT) begin
            n_track.fmt_found    = 1'b1;
            n_track.fmt_position = r_track.byte_count - CB'(3);
        end
        if (w_scan && !r_track.data_found && n_window == whp_pkg::TAG_DATA) begin
            n_track.data_found    = 1'b1;
            n_track.data_position = r_track.byte_count - CB'(3);
        end

        // Channel count sits at tag+10, sample rate at tag+12.
        if (r_track.fmt_found && w_fmt_dist[CB-1:4] == '0) begin
            case (w_fmt_dist[3:0])
                4'd10:   n_track.channels[7:0]  = i_file_byte;
                4'd11:   n_track.channels[15:8] = i_file_byte;
                4'd12:   n_track.rate[7:0]      = i_file_byte;
                4'd13:   n_track.rate[15:8]     = i_file_byte;
                4'd14:   n_track.rate[23:16]    = i_file_byte;
                4'd15:   n_track.rate[31:24]    = i_file_byte;
                default: ;
            endcase
        end
        // Chunk size sits at tag+4.
        if (r_track.data_found && w_data_dist[CB-1:3] == '0) begin
            case (w_data_dist[2:0])
                3'd4:    n_track.size[7:0]   = i_file_byte;
                3'd5:    n_track.size[15:8]  = i_file_byte;
                3'd6:    n_track.size[23:16] = i_file_byte;
                3'd7:    n_track.size[31:24] = i_file_byte;
                default: ;
            endcase
        end

        // The counter sticks at its maximum on very long files.
        if (r_track.byte_count != '1) begin
            n_track.byte_count = r_track.byte_count + CB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_track  <= '0;
        end else if (i_accept) begin
            if (i_is_last) begin
                r_window <= '0;
                r_track  <= '0;
            end else begin
                r_window <= n_window;
                r_track  <= n_track;
            end
        end
    end

    assign o_track = r_track;

endmodule
`default_nettype wire

// File: hdl/whp_result.sv
// Final header checks on the last byte and the registered result stage.
`default_nettype none
module whp_result (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_is_last,
    input  wire whp_pkg::t_track i_track,
    input  wire logic            i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output whp_pkg::t_status     o_status,
    output logic [31:0]          o_sample_rate,
    output logic [15:0]          o_channel_count,
    output logic [31:0]          o_payload_offset,
    output logic [31:0]          o_payload_size
);

    localparam int CB = whp_pkg::COUNT_BITS;
    localparam int SW = whp_pkg::SUM_W;

    logic [CB:0]        w_len;
    logic [CB:0]        w_fmt_limit;
    logic [SW-1:0]      w_data_start;
    logic [SW-1:0]      w_data_end;
    logic               w_accept;
    whp_pkg::t_status   w_status;

    logic               r_valid;
    whp_pkg::t_status   r_status;
    logic [31:0]        r_rate;
    logic [15:0]        r_channels;
    logic [31:0]        r_offset;
    logic [31:0]        r_size;

    // The checks read the state as it stood before the last byte; any field
    // that this byte could still complete already fails an earlier check.
    assign w_len        = {1'b0, i_track.byte_count} + (CB+1)'(1);
    assign w_fmt_limit  = {1'b0, i_track.fmt_position} + (CB+1)'(whp_pkg::FMT_TAIL);
    assign w_data_start = SW'(i_track.data_position) + SW'(whp_pkg::DATA_HDR_LEN);
    assign w_data_end   = w_data_start + SW'(i_track.size);

    always_comb begin
        if (w_len < (CB+1)'(whp_pkg::MIN_FILE_LEN)) begin
            w_status = whp_pkg::ST_SHORT;
        end else if (!i_track.riff_seen) begin
            w_status = whp_pkg::ST_NO_RIFF;
        end else if (!i_track.wave_seen) begin
            w_status = whp_pkg::ST_NO_WAVE;
        end else if (!i_track.fmt_found || w_fmt_limit >= w_len) begin
            w_status = whp_pkg::ST_NO_FMT;
        end else if (!i_track.data_found || w_data_start >= SW'(w_len)) begin
            w_status = whp_pkg::ST_NO_DATA;
        end else if (w_data_end > SW'(w_len)) begin
            w_status = whp_pkg::ST_OVERRUN;
        end else begin
            w_status = whp_pkg::ST_OK;
        end
    end

    assign o_in_ready = !r_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept && i_is_last) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_is_last) begin
            r_status <= w_status;
            if (w_status == whp_pkg::ST_OK) begin
                r_rate     <= i_track.rate;
                r_channels <= i_track.channels;
                r_offset   <= w_data_start[31:0];
                r_size     <= i_track.size;
            end else begin
                r_rate     <= '0;
                r_channels <= '0;
                r_offset   <= '0;
                r_size     <= '0;
            end
        end
    end

    assign o_out_valid      = r_valid;
    assign o_status         = r_status;
    assign o_sample_rate    = r_rate;
    assign o_channel_count  = r_channels;
    assign o_payload_offset = r_offset;
    assign o_payload_size   = r_size;

endmodule
`default_nettype wire

// File: hdl/wav_header_parser_core.sv
// Top level of the WAV header parser: byte stream in, one header result per file out.
// The file arrives on i_byte one byte per transaction in file order, with is_last
// set on its final byte. Bytes without is_last produce nothing; the transaction that
// carries is_last produces exactly one transaction on o_result holding the status
// code, sample rate, channel count, payload offset and payload size. Every field but
// the status reads zero when the status is not ok.
// Throughput is one byte per cycle: each byte only shifts a four-byte tag window,
// compares it against the chunk tags, counts it and may write one field byte.
// The result appears in the cycle after the final byte is accepted, from the output
// register. While that register holds a result the receiver has not taken,
// i_byte.ready is low; it rises again in the cycle the receiver takes the result,
// so the next file may follow without a gap when o_result.ready is held high.
// After the final byte all tracking state returns to zero, ready for the next file.
// Reset is synchronous and active low; it clears the tracking state and the
// output valid flag, and the block accepts bytes from the first cycle after reset.
`default_nettype none
module wav_header_parser_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    whp_in_if.sink     i_byte,
    whp_out_if.source  o_result
);

    whp_pkg::t_track   w_track;
    whp_pkg::t_status  w_status;
    logic              w_in_ready;
    logic              w_accept;

    assign w_accept     = i_byte.valid && w_in_ready;
    assign i_byte.ready = w_in_ready;

    whp_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_file_byte (i_byte.file_byte),
        .i_is_last   (i_byte.is_last),
        .o_track     (w_track)
    );

    whp_result u_result (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_byte.valid),
        .i_is_last        (i_byte.is_last),
        .i_track          (w_track),
        .i_out_ready      (o_result.ready),
        .o_in_ready       (w_in_ready),
        .o_out_valid      (o_result.valid),
        .o_status         (w_status),
        .o_sample_rate    (o_result.sample_rate),
        .o_channel_count  (o_result.channel_count),
        .o_payload_offset (o_result.payload_offset),
        .o_payload_size   (o_result.payload_size)
    );

    assign o_result.status = w_status;

endmodule
`default_nettype wire
